[hdl/mqrf_pkg.sv]
// shared constants, types and ring helpers for the multi-queue ring fifo
package mqrf_pkg;

    // geometry
    localparam int NUM_QUEUES  = 4;
    localparam int MAX_SLOTS   = 16;
    localparam int ELEM_BITS   = 32;
    localparam int STORE_DEPTH = NUM_QUEUES * MAX_SLOTS;

    // widths
    localparam int QID_W      = 2;
    localparam int ACTION_W   = 3;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 4;
    localparam int ACT_W      = 3;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_SLOT_Q = 4;
    localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOTS_W    = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    // reset value of a slot count register
    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_COUNT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd3;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_Q0  = 3'd1;

    // slot store access issued with an accepted transaction
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } mem_req_t;

    // result fields known at acceptance, data follows from the store
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                full;
        logic                empty;
        logic                rd_sel;
    } result_t;

    // slot count clamped to the legal range
    function automatic logic [SLOTS_W-1:0] clamp_slots(input logic [CFG_W-1:0] v);
        logic [SLOTS_W-1:0] s;
        if (int'(v) < 2)
            s = SLOTS_W'(2);
        else if (int'(v) > MAX_SLOTS)
            s = SLOTS_W'(MAX_SLOTS);
        else
            s = SLOTS_W'(v);
        return s;
    endfunction

    // active count clamped to the number of queues
    function automatic logic [ACT_W-1:0] clamp_active(input logic [ACT_W-1:0] v);
        logic [ACT_W-1:0] a;
        if (int'(v) > NUM_QUEUES)
            a = ACT_W'(NUM_QUEUES);
        else
            a = v;
        return a;
    endfunction

    // advance a ring index, wrapping at the slot count
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                   input logic [SLOTS_W-1:0] s);
        logic [SLOTS_W-1:0] n;
        logic [IDX_W-1:0]   r;
        n = SLOTS_W'(idx) + SLOTS_W'(1);
        if (n >= s)
            r = '0;
        else
            r = n[IDX_W-1:0];
        return r;
    endfunction

    // entries held between front and rear
    function automatic logic [COUNT_W-1:0] ring_count(input logic [IDX_W-1:0] f,
                                                      input logic [IDX_W-1:0] r,
                                                      input logic [SLOTS_W-1:0] s);
        logic [SLOTS_W-1:0] c;
        if (r < f)
            c = s - SLOTS_W'(f) + SLOTS_W'(r);
        else
            c = SLOTS_W'(r) - SLOTS_W'(f);
        return c[COUNT_W-1:0];
    endfunction

    // flat store address of a queue slot
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [QID_W-1:0] q,
                                                    input logic [IDX_W-1:0] idx);
        return ADDR_W'(int'(q) * MAX_SLOTS + int'(idx));
    endfunction

endpackage

[hdl/mqrf_slot_ram.sv]
// single-port slot store with registered read data
module mqrf_slot_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[addr] <= wdata;
    end

    // read port, data registered when re is high
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mqrf_ctrl.sv]
// queue index state, configuration registers and per-transaction decision
module mqrf_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mqrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mqrf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 accept,
    input  logic [mqrf_pkg::ACTION_W-1:0]        action,
    input  logic [mqrf_pkg::QID_W-1:0]           queue_id,
    output mqrf_pkg::mem_req_t                   mem_req,
    output mqrf_pkg::result_t                    result
);

    logic [mqrf_pkg::ACT_W-1:0]   active_reg;
    logic [mqrf_pkg::CFG_W-1:0]   slots_reg [0:mqrf_pkg::CFG_SLOT_Q-1];
    logic [mqrf_pkg::IDX_W-1:0]   front_reg [0:mqrf_pkg::NUM_QUEUES-1];
    logic [mqrf_pkg::IDX_W-1:0]   rear_reg  [0:mqrf_pkg::NUM_QUEUES-1];

    logic [mqrf_pkg::ACT_W-1:0]   eff_active;
    logic [mqrf_pkg::ACT_W-1:0]   new_active;
    logic                         q_active;
    logic [mqrf_pkg::SLOTS_W-1:0] sel_slots;
    logic [mqrf_pkg::IDX_W-1:0]   sel_front;
    logic [mqrf_pkg::IDX_W-1:0]   sel_rear;
    logic [mqrf_pkg::IDX_W-1:0]   nxt_front;
    logic [mqrf_pkg::IDX_W-1:0]   nxt_rear;
    logic [mqrf_pkg::IDX_W-1:0]   sel_front_next;
    logic [mqrf_pkg::IDX_W-1:0]   sel_rear_next;
    logic                         do_write;
    logic                         do_read;
    logic [mqrf_pkg::ADDR_W-1:0]  acc_addr;
    logic [mqrf_pkg::STATUS_W-1:0] acc_status;

    assign eff_active = mqrf_pkg::clamp_active(active_reg);
    assign new_active = mqrf_pkg::clamp_active(cfg_data[mqrf_pkg::ACT_W-1:0]);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < mqrf_pkg::CFG_SLOT_Q; i++)
                slots_reg[i] <= mqrf_pkg::SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mqrf_pkg::REG_ACTIVE)
                active_reg <= cfg_data[mqrf_pkg::ACT_W-1:0];
            for (int i = 0; i < mqrf_pkg::CFG_SLOT_Q; i++)
                if (int'(cfg_index) == int'(mqrf_pkg::REG_SLOTS_Q0) + i)
                    slots_reg[i] <= cfg_data;
        end
    end

    // decision for the presented transaction
    always_comb
    begin
        sel_front  = front_reg[queue_id];
        sel_rear   = rear_reg[queue_id];
        sel_slots  = mqrf_pkg::clamp_slots(slots_reg[queue_id]);
        nxt_front  = mqrf_pkg::ring_next(sel_front, sel_slots);
        nxt_rear   = mqrf_pkg::ring_next(sel_rear, sel_slots);
        q_active   = (int'(queue_id) < mqrf_pkg::NUM_QUEUES)
                     && (mqrf_pkg::ACT_W'(queue_id) < eff_active);

        sel_front_next = sel_front;
        sel_rear_next  = sel_rear;
        acc_status     = mqrf_pkg::ST_DONE;
        do_write       = 1'b0;
        do_read        = 1'b0;
        acc_addr       = mqrf_pkg::slot_addr(queue_id, nxt_front);

        if (!q_active)
            acc_status = mqrf_pkg::ST_INACTIVE;
        else
        begin
            unique case (action)
                mqrf_pkg::ACT_PUSH:
                begin
                    acc_addr = mqrf_pkg::slot_addr(queue_id, nxt_rear);
                    if (nxt_rear == sel_front)
                        acc_status = mqrf_pkg::ST_FULL;
                    else
                    begin
                        sel_rear_next = nxt_rear;
                        do_write      = 1'b1;
                    end
                end
                mqrf_pkg::ACT_POP, mqrf_pkg::ACT_PEEK:
                begin
                    if (sel_front == sel_rear)
                        acc_status = mqrf_pkg::ST_EMPTY;
                    else
                    begin
                        do_read = 1'b1;
                        if (action == mqrf_pkg::ACT_POP)
                            sel_front_next = nxt_front;
                    end
                end
                mqrf_pkg::ACT_CLEAR:
                begin
                    sel_front_next = '0;
                    sel_rear_next  = '0;
                end
                // count query and unused codes leave the queue alone
                default:
                begin
                end
            endcase
        end

        mem_req.we   = accept && do_write;
        mem_req.re   = accept && do_read;
        mem_req.addr = acc_addr;

        result.status = acc_status;
        result.rd_sel = do_read;
        if (q_active)
        begin
            result.count = mqrf_pkg::ring_count(sel_front_next, sel_rear_next, sel_slots);
            result.full  = mqrf_pkg::ring_next(sel_rear_next, sel_slots) == sel_front_next;
            result.empty = sel_front_next == sel_rear_next;
        end
        else
        begin
            result.count = '0;
            result.full  = 1'b0;
            result.empty = 1'b0;
        end
    end

    // front and rear indices per queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < mqrf_pkg::NUM_QUEUES; q++)
            begin
                front_reg[q] <= '0;
                rear_reg[q]  <= '0;
            end
        end
        else
        begin
            for (int q = 0; q < mqrf_pkg::NUM_QUEUES; q++)
            begin
                if (cfg_we && (cfg_index == mqrf_pkg::REG_ACTIVE)
                    && (q >= int'(eff_active)) && (q < int'(new_active)))
                begin
                    front_reg[q] <= '0;
                    rear_reg[q]  <= '0;
                end
                else if (cfg_we && (int'(cfg_index) == int'(mqrf_pkg::REG_SLOTS_Q0) + q))
                begin
                    front_reg[q] <= '0;
                    rear_reg[q]  <= '0;
                end
                else if (accept && (int'(queue_id) == q))
                begin
                    front_reg[q] <= sel_front_next;
                    rear_reg[q]  <= sel_rear_next;
                end
            end
        end
    end

endmodule

[hdl/multi_queue_ring_fifo.sv]
// top level of the multi-queue ring fifo: handshakes, result staging, checks
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | to block  | in_valid / in_ready    | action, queue_id, data_in
//  out     | from block| out_valid / out_ready  | status, data_out, count, is_full, is_empty
//  cfg     | to block  | cfg_we (no wait)       | cfg_index, cfg_data
//
// one transaction per cycle while results are taken; a result passes from the pending
// stage to the output registers; slot store read data is registered with the pending stage.
// indices update at acceptance, so the next transaction sees them.
// reset empties every queue, deactivates all queues and sets every slot count to 16.
// a stalled output holds the pending stage; in_ready drops until the output moves.
module multi_queue_ring_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mqrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mqrf_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mqrf_pkg::ACTION_W-1:0]     action,
    input  logic [mqrf_pkg::QID_W-1:0]        queue_id,
    input  logic [mqrf_pkg::DATA_W-1:0]       data_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mqrf_pkg::STATUS_W-1:0]     status,
    output logic [mqrf_pkg::DATA_W-1:0]       data_out,
    output logic [mqrf_pkg::COUNT_W-1:0]      count,
    output logic                              is_full,
    output logic                              is_empty
);

    logic                              accept;
    logic                              move;
    mqrf_pkg::mem_req_t                mem_req;
    mqrf_pkg::result_t                 acc_res;
    logic [mqrf_pkg::ELEM_BITS-1:0]    rd_data;

    logic                              pend_reg;
    logic                              pend_next;
    mqrf_pkg::result_t                 pend_res_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    mqrf_pkg::result_t                 out_res_reg;
    logic [mqrf_pkg::DATA_W-1:0]       out_data_reg;

    // handshake
    assign move     = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg || move;
    assign accept   = in_valid && in_ready;

    mqrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .action    (action),
        .queue_id  (queue_id),
        .mem_req   (mem_req),
        .result    (acc_res)
    );

    mqrf_slot_ram #(
        .ADDR_W (mqrf_pkg::ADDR_W),
        .DATA_W (mqrf_pkg::ELEM_BITS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mqrf_pkg::ELEM_BITS'(data_in)),
        .rdata (rd_data)
    );

    // stage valid flags
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
            pend_next = 1'b1;
        else if (move)
            pend_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pending and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_res_reg <= acc_res;
        if (move)
        begin
            out_res_reg  <= pend_res_reg;
            out_data_reg <= pend_res_reg.rd_sel ? mqrf_pkg::DATA_W'(rd_data) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign data_out  = out_data_reg;
    assign count     = out_res_reg.count;
    assign is_full   = out_res_reg.full;
    assign is_empty  = out_res_reg.empty;

    // a pending result with room ahead reaches the output
    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("pending result did not reach the output");

    // an inactive queue reports nothing else
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status == mqrf_pkg::ST_INACTIVE))
        |-> (count == '0) && !is_full && !is_empty)
        else $error("inactive queue result carries nonzero fields");

    // read data is zero on any failing status
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status != mqrf_pkg::ST_DONE)) |-> (data_out == '0))
        else $error("data returned with a failing status");

    // a queue is never full and empty at once
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(is_full && is_empty))
        else $error("queue reported full and empty together");

endmodule
